// File: sv/ospid_pkg.sv
// Shared constants and types for the one-sided PID controller core.
// Field widths, serial unit sizes and configuration register indexes.
// No dependencies; imported by every module of the block.
`default_nettype none

package ospid_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 32;
	localparam int GAIN_W     = 16;
	localparam int INTEG_W    = 32;
	localparam int DRIVE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int ERR_W  = 16;
	localparam int DIFF_W = ERR_W + 1;

	// Shift-add multiplier: unsigned multiplier scanned one bit per cycle,
	// signed multiplicand.
	localparam int MUL_N     = GAIN_W;
	localparam int MUL_X_W   = TIME_W + 1;
	localparam int MUL_P_W   = MUL_X_W + 1 + MUL_N;
	localparam int MUL_CNT_W = $clog2(MUL_N);

	// Restoring divider: one quotient bit per cycle.
	localparam int DIV_N     = ERR_W;
	localparam int DIV_Q_W   = DIV_N + 1;
	localparam int DIV_CNT_W = $clog2(DIV_N);

	localparam int SUM_W     = MUL_P_W + 1;
	localparam int ACC_W     = MUL_P_W + 1;
	localparam int PTERM_W   = 2 * GAIN_W;
	localparam int FRAC_BITS = 8;
	localparam int RND_HALF  = 1 << (FRAC_BITS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT       = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3,
		REG_INTEG_UPPER    = 3'd4,
		REG_INTEG_LOWER    = 3'd5,
		REG_DRIVE_UPPER    = 3'd6,
		REG_DRIVE_LOWER    = 3'd7
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/one_sided_pid_controller_core.sv
// Top level of the one-sided PID controller: configuration registers, sequencer
// and controller state. Depends on ospid_pkg, ospid_smul and ospid_sdiv.
//
//   Channel   Handshake              Payload
//   ------    ---------------------  ------------------------------------
//   request   req_valid / req_ready  sample, timestamp_ms, time_ok
//   response  rsp_valid / rsp_ready  drive, status
//   config    cfg_we (no wait)       cfg_addr, cfg_data
//
// A good transaction runs two passes through the bit-serial multipliers, the
// first pass shared by the serial divider for the derivative, before its
// response is loaded. A transaction with a time fault skips both passes and
// loads its response once the output register is free. No new request is
// accepted until the previous response has been loaded.
// Reset restores the register defaults and clears the integral, the previous
// error and the previous timestamp. A stalled response is held in the output
// register while the next request is already being processed.
`default_nettype none

module one_sided_pid_controller_core import ospid_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [TIME_W-1:0]          timestamp_ms,
	input  logic                       time_ok,

	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic signed [DRIVE_W-1:0]  drive,
	output logic                       status,

	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_addr,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RUN1,
		ST_INTEG,
		ST_CLAMP,
		ST_START2,
		ST_RUN2,
		ST_ACC1,
		ST_ACC2,
		ST_DONE
	} state_t;

	// Configuration registers.
	logic signed [SAMPLE_W-1:0] setpoint_q;
	logic [GAIN_W-1:0]          gain_p_q;
	logic [GAIN_W-1:0]          gain_i_q;
	logic [GAIN_W-1:0]          gain_d_q;
	logic signed [INTEG_W-1:0]  integ_upper_q;
	logic signed [INTEG_W-1:0]  integ_lower_q;
	logic signed [DRIVE_W-1:0]  drive_upper_q;
	logic signed [DRIVE_W-1:0]  drive_lower_q;

	// Controller state carried from one good transaction to the next.
	logic signed [INTEG_W-1:0]  integral_q;
	logic [ERR_W-1:0]           prev_error_q;
	logic [TIME_W-1:0]          prev_time_q;

	// Per-transaction working registers.
	state_t                     state_q;
	logic [ERR_W-1:0]           err_q;
	logic [TIME_W-1:0]          now_q;
	logic                       fault_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [PTERM_W-1:0]         pterm_q;
	logic signed [DIV_Q_W-1:0]  deriv_q;
	logic signed [ACC_W-1:0]    acc_q;

	// Output register.
	logic                       rsp_valid_q;
	logic signed [DRIVE_W-1:0]  drive_q;
	logic                       status_q;

	logic signed [DIFF_W-1:0]   diff_c;
	logic [ERR_W-1:0]           err_c;
	logic [TIME_W-1:0]          dt_c;
	logic signed [DIV_Q_W-1:0]  num_c;

	logic                       start1;
	logic                       start2;
	logic [MUL_N-1:0]           mul_a_mplier;
	logic signed [MUL_X_W-1:0]  mul_a_mcand;
	logic [MUL_N-1:0]           mul_b_mplier;
	logic signed [MUL_X_W-1:0]  mul_b_mcand;
	logic                       mul_a_busy;
	logic                       mul_b_busy;
	logic                       div_busy;
	logic signed [MUL_P_W-1:0]  mul_a_prod;
	logic signed [MUL_P_W-1:0]  mul_b_prod;
	logic signed [DIV_Q_W-1:0]  div_quot;
	logic                       units_busy;

	logic signed [SUM_W-1:0]    integ_upper_ext;
	logic signed [SUM_W-1:0]    integ_lower_ext;
	logic signed [INTEG_W-1:0]  integ_clamped;
	logic signed [ACC_W-1:0]    drv_full;
	logic signed [ACC_W-1:0]    drive_upper_ext;
	logic signed [ACC_W-1:0]    drive_lower_ext;
	logic signed [DRIVE_W-1:0]  drv_sat;
	logic                       load_ok;
	logic                       rsp_load;

	// Error is only produced while the sample is above the setpoint.
	assign diff_c = {sample[SAMPLE_W-1], sample} - {setpoint_q[SAMPLE_W-1], setpoint_q};
	assign err_c  = (!diff_c[DIFF_W-1] && (diff_c != '0)) ? diff_c[ERR_W-1:0] : '0;
	// Elapsed time wraps with the millisecond counter.
	assign dt_c   = timestamp_ms - prev_time_q;
	assign num_c  = $signed({1'b0, err_c}) - $signed({1'b0, prev_error_q});

	assign req_ready  = (state_q == ST_IDLE);
	assign start1     = req_ready && req_valid && time_ok;
	assign start2     = (state_q == ST_START2);
	assign units_busy = mul_a_busy || mul_b_busy || div_busy;

	// First pass: A forms error * dt, B forms gain_p * error, the divider forms the
	// derivative. Second pass: A forms gain_i * integral, B forms gain_d * derivative.
	always_comb begin
		if (state_q == ST_IDLE) begin
			mul_a_mplier = err_c;
			mul_a_mcand  = $signed({1'b0, dt_c});
			mul_b_mplier = gain_p_q;
			mul_b_mcand  = $signed({{(MUL_X_W-ERR_W){1'b0}}, err_c});
		end else begin
			mul_a_mplier = gain_i_q;
			mul_a_mcand  = {integral_q[INTEG_W-1], integral_q};
			mul_b_mplier = gain_d_q;
			mul_b_mcand  = {{(MUL_X_W-DIV_Q_W){deriv_q[DIV_Q_W-1]}}, deriv_q};
		end
	end

	ospid_smul u_mul_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start1 || start2),
		.mplier  (mul_a_mplier),
		.mcand   (mul_a_mcand),
		.busy    (mul_a_busy),
		.product (mul_a_prod)
	);

	ospid_smul u_mul_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start1 || start2),
		.mplier  (mul_b_mplier),
		.mcand   (mul_b_mcand),
		.busy    (mul_b_busy),
		.product (mul_b_prod)
	);

	ospid_sdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start1),
		.num    (num_c),
		.dvs    (dt_c),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// With crossed limits, a sum above the upper limit takes it; any other sum takes the lower limit.
	assign integ_upper_ext = {{(SUM_W-INTEG_W){integ_upper_q[INTEG_W-1]}}, integ_upper_q};
	assign integ_lower_ext = {{(SUM_W-INTEG_W){integ_lower_q[INTEG_W-1]}}, integ_lower_q};
	always_comb begin
		if (sum_q > integ_upper_ext) begin
			integ_clamped = integ_upper_q;
		end else if (sum_q < integ_lower_ext) begin
			integ_clamped = integ_lower_q;
		end else begin
			integ_clamped = sum_q[INTEG_W-1:0];
		end
	end

	// The half-LSB rounding term is already in acc_q, so a floor shift finishes it.
	assign drv_full        = acc_q >>> FRAC_BITS;
	assign drive_upper_ext = {{(ACC_W-DRIVE_W){drive_upper_q[DRIVE_W-1]}}, drive_upper_q};
	assign drive_lower_ext = {{(ACC_W-DRIVE_W){drive_lower_q[DRIVE_W-1]}}, drive_lower_q};
	always_comb begin
		if (drv_full > drive_upper_ext) begin
			drv_sat = drive_upper_q;
		end else if (drv_full < drive_lower_ext) begin
			drv_sat = drive_lower_q;
		end else begin
			drv_sat = drv_full[DRIVE_W-1:0];
		end
	end

	assign load_ok  = !rsp_valid_q || rsp_ready;
	// A new response is loaded in the same cycle that frees the output register.
	assign rsp_load = (state_q == ST_DONE) && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q    <= '0;
			gain_p_q      <= GAIN_W'(256);
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			integ_upper_q <= {1'b0, {(INTEG_W-1){1'b1}}};
			integ_lower_q <= '0;
			drive_upper_q <= {1'b0, {(DRIVE_W-1){1'b1}}};
			drive_lower_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_SETPOINT:    setpoint_q    <= cfg_data[SAMPLE_W-1:0];
				REG_GAIN_P:      gain_p_q      <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:      gain_i_q      <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:      gain_d_q      <= cfg_data[GAIN_W-1:0];
				REG_INTEG_UPPER: integ_upper_q <= cfg_data[INTEG_W-1:0];
				REG_INTEG_LOWER: integ_lower_q <= cfg_data[INTEG_W-1:0];
				REG_DRIVE_UPPER: drive_upper_q <= cfg_data[DRIVE_W-1:0];
				REG_DRIVE_LOWER: drive_lower_q <= cfg_data[DRIVE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			integral_q   <= '0;
			prev_error_q <= '0;
			prev_time_q  <= '0;
			err_q        <= '0;
			now_q        <= '0;
			fault_q      <= 1'b0;
			sum_q        <= '0;
			pterm_q      <= '0;
			deriv_q      <= '0;
			acc_q        <= '0;
			rsp_valid_q  <= 1'b0;
			drive_q      <= '0;
			status_q     <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						err_q   <= err_c;
						now_q   <= timestamp_ms;
						fault_q <= !time_ok;
						state_q <= time_ok ? ST_RUN1 : ST_DONE;
					end
				end
				ST_RUN1: begin
					if (!units_busy) begin
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: begin
					sum_q   <= {{(SUM_W-INTEG_W){integral_q[INTEG_W-1]}}, integral_q}
						+ {mul_a_prod[MUL_P_W-1], mul_a_prod};
					pterm_q <= mul_b_prod[PTERM_W-1:0];
					deriv_q <= div_quot;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					// State advances only for a good transaction.
					integral_q   <= integ_clamped;
					prev_error_q <= err_q;
					prev_time_q  <= now_q;
					state_q      <= ST_START2;
				end
				ST_START2: begin
					state_q <= ST_RUN2;
				end
				ST_RUN2: begin
					if (!units_busy) begin
						state_q <= ST_ACC1;
					end
				end
				ST_ACC1: begin
					acc_q   <= {mul_a_prod[MUL_P_W-1], mul_a_prod}
						+ {mul_b_prod[MUL_P_W-1], mul_b_prod};
					state_q <= ST_ACC2;
				end
				ST_ACC2: begin
					acc_q   <= acc_q + $signed({{(ACC_W-PTERM_W){1'b0}}, pterm_q})
						+ ACC_W'(RND_HALF);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_ok) begin
						drive_q     <= fault_q ? '0 : drv_sat;
						status_q    <= fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign drive     = drive_q;
	assign status    = status_q;

	a_fault_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> drive == '0)
		else $error("time fault response carries a nonzero drive");

	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !units_busy)
		else $error("serial unit still running while a request can be accepted");

	a_drive_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !status |-> (drive <= drive_upper_q) || (drive == drive_lower_q))
		else $error("drive outside the configured saturation range");

	a_integral_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START2 |-> (integral_q <= integ_upper_q) || (integral_q == integ_lower_q))
		else $error("integral outside the configured clamp range");

endmodule

`default_nettype wire

// File: sv/ospid_smul.sv
// Bit-serial shift-add multiplier: unsigned multiplier times signed multiplicand.
// Depends on ospid_pkg.
`default_nettype none

module ospid_smul import ospid_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [MUL_N-1:0]          mplier,
	input  logic signed [MUL_X_W-1:0] mcand,
	output logic                      busy,
	output logic signed [MUL_P_W-1:0] product
);

	logic signed [MUL_X_W:0]   hi_q;
	logic [MUL_N-1:0]          lo_q;
	logic signed [MUL_X_W-1:0] x_q;
	logic [MUL_CNT_W-1:0]      cnt_q;
	logic                      busy_q;
	logic signed [MUL_X_W:0]   addend;
	logic signed [MUL_X_W:0]   psum;

	assign addend  = lo_q[0] ? {x_q[MUL_X_W-1], x_q} : '0;
	assign psum    = hi_q + addend;
	assign busy    = busy_q;
	assign product = $signed({hi_q, lo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= MUL_CNT_W'(MUL_N - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The partial product shifts right while the multiplier bits drain out below it.
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= mplier;
			x_q  <= mcand;
		end else if (busy_q) begin
			hi_q <= psum >>> 1;
			lo_q <= {psum[0], lo_q[MUL_N-1:1]};
		end
	end

endmodule

`default_nettype wire

// File: sv/ospid_sdiv.sv
// Bit-serial restoring divider: signed numerator over unsigned divisor,
// quotient truncated toward zero, zero when the divisor is zero. Depends on ospid_pkg.
`default_nettype none

module ospid_sdiv import ospid_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [DIV_Q_W-1:0] num,
	input  logic [TIME_W-1:0]         dvs,
	output logic                      busy,
	output logic signed [DIV_Q_W-1:0] quot
);

	logic [DIV_N-1:0]         n_q;
	logic [TIME_W-1:0]        r_q;
	logic [TIME_W-1:0]        d_q;
	logic                     neg_q;
	logic                     zero_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic signed [DIV_Q_W-1:0] num_mag;
	logic [TIME_W+1:0]        trial;
	logic                     fit;
	logic signed [DIV_Q_W-1:0] q_ext;

	assign num_mag = num[DIV_Q_W-1] ? -num : num;
	assign trial   = {1'b0, r_q, n_q[DIV_N-1]} - {2'b00, d_q};
	assign fit     = !trial[TIME_W+1];
	assign q_ext   = $signed({1'b0, n_q});
	assign quot    = zero_q ? '0 : (neg_q ? -q_ext : q_ext);
	assign busy    = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_N - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Numerator bits leave at the top of n_q while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= num_mag[DIV_N-1:0];
			r_q    <= '0;
			d_q    <= dvs;
			neg_q  <= num[DIV_Q_W-1];
			zero_q <= (dvs == '0);
		end else if (busy_q) begin
			if (fit) begin
				r_q <= trial[TIME_W-1:0];
			end else begin
				r_q <= {r_q[TIME_W-2:0], n_q[DIV_N-1]};
			end
			n_q <= {n_q[DIV_N-2:0], fit};
		end
	end

endmodule

`default_nettype wire

// File: tb/one_sided_pid_controller_core_tb.sv
// Self-checking testbench for the one-sided PID controller core.
// It depends on ospid_pkg and one_sided_pid_controller_core. A built-in
// predictor checks every response under random handshake pressure.
`default_nettype none

module one_sided_pid_controller_core_tb import ospid_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// One request transaction as the driver holds it. When hold_off is set,
	// the driver waits until every outstanding response has come back before
	// it presents the item.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [TIME_W-1:0]          timestamp_ms;
		logic                       time_ok;
		logic                       hold_off;
	} pid_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      status;
	} pid_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic [TIME_W-1:0]          timestamp_ms = '0;
	logic                       time_ok = 1'b0;
	logic                       rsp_valid;
	logic                       rsp_ready = 1'b0;
	logic signed [DRIVE_W-1:0]  drive;
	logic                       status;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_addr = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	one_sided_pid_controller_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.sample       (sample),
		.timestamp_ms (timestamp_ms),
		.time_ok      (time_ok),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.drive        (drive),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Copies of the configuration registers, kept in step with every write.
	logic signed [SAMPLE_W-1:0] cp_setpoint;
	logic [GAIN_W-1:0]          cp_gain_p;
	logic [GAIN_W-1:0]          cp_gain_i;
	logic [GAIN_W-1:0]          cp_gain_d;
	logic signed [INTEG_W-1:0]  cp_integ_upper;
	logic signed [INTEG_W-1:0]  cp_integ_lower;
	logic signed [DRIVE_W-1:0]  cp_drive_upper;
	logic signed [DRIVE_W-1:0]  cp_drive_lower;

	// Controller state as the predictor sees it.
	logic signed [INTEG_W-1:0] pr_integral;
	logic [ERR_W-1:0]          pr_prev_error;
	logic [TIME_W-1:0]         pr_prev_time;

	pid_item_t   stim_q[$];
	pid_result_t drive_expect_q[$];

	pid_item_t   cur_item;
	pid_result_t want;
	logic        presenting = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;
	int          fail_count = 0;

	// Computes the response of one accepted request and advances the
	// predicted controller state. A time fault leaves the state untouched.
	function automatic pid_result_t pid_step(input pid_item_t it);
		pid_result_t r;
		longint smp, sp, err, sum, deriv, acc, drv;
		logic [TIME_W-1:0] dt;
		if (!it.time_ok) begin
			r.drive = '0;
			r.status = 1'b1;
			return r;
		end
		smp = longint'(it.sample);
		sp = longint'(cp_setpoint);
		// Only a sample above the setpoint produces error.
		err = (smp > sp) ? smp - sp : 0;
		// Elapsed time wraps modulo 2^32, which also covers the first item
		// after reset, where the previous time is zero.
		dt = it.timestamp_ms - pr_prev_time;
		sum = longint'(pr_integral) + err * longint'(dt);
		// With crossed limits, a sum above the upper clamp takes it; any other sum takes the lower clamp.
		if (sum > longint'(cp_integ_upper))
			sum = longint'(cp_integ_upper);
		else if (sum < longint'(cp_integ_lower))
			sum = longint'(cp_integ_lower);
		// Zero elapsed time gives no derivative; division truncates toward zero.
		if (dt == 0)
			deriv = 0;
		else
			deriv = (err - longint'(pr_prev_error)) / longint'(dt);
		acc = longint'(cp_gain_p) * err + longint'(cp_gain_i) * sum
			+ longint'(cp_gain_d) * deriv;
		// Round half up back to Q8.8: an arithmetic shift is a floor division.
		drv = (acc + RND_HALF) >>> FRAC_BITS;
		if (drv > longint'(cp_drive_upper))
			drv = longint'(cp_drive_upper);
		else if (drv < longint'(cp_drive_lower))
			drv = longint'(cp_drive_lower);
		pr_integral = sum[INTEG_W-1:0];
		pr_prev_error = err[ERR_W-1:0];
		pr_prev_time = it.timestamp_ms;
		r.drive = drv[DRIVE_W-1:0];
		r.status = 1'b0;
		return r;
	endfunction

	// Number of idle cycles before the next transaction on either side.
	function automatic int draw_wait();
		return calm ? 0 : int'($urandom_range(0, 6));
	endfunction

	function automatic pid_item_t mk_item(input logic signed [SAMPLE_W-1:0] s,
			input logic [TIME_W-1:0] ts, input logic ok, input logic hold);
		pid_item_t it;
		it.sample = s;
		it.timestamp_ms = ts;
		it.time_ok = ok;
		it.hold_off = hold;
		return it;
	endfunction

	// Request driver. The item is predicted at the edge where it is accepted.
	// The valid is assigned once per edge, so a back-to-back item keeps it high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			presenting = 1'b0;
			gap_left = 0;
		end else begin
			if (req_valid && req_ready) begin
				drive_expect_q.push_back(pid_step(cur_item));
				presenting = 1'b0;
				gap_left = draw_wait();
			end
			if (!presenting) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() != 0 &&
						!(stim_q[0].hold_off && drive_expect_q.size() != 0)) begin
					cur_item = stim_q.pop_front();
					sample <= cur_item.sample;
					timestamp_ms <= cur_item.timestamp_ms;
					time_ok <= cur_item.time_ok;
					presenting = 1'b1;
				end
			end
			req_valid <= presenting;
		end
	end

	// Response monitor. Each accepted response is checked against the oldest
	// expectation; ready may then drop for a stall drawn by draw_wait.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (drive_expect_q.size() == 0) begin
					$error("response with nothing expected: drive %0d status %0d",
						drive, status);
					fail_count++;
				end else begin
					want = drive_expect_q.pop_front();
					if (drive !== want.drive) begin
						$error("drive mismatch: expected %0d, actual %0d",
							want.drive, drive);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
						fail_count++;
					end
				end
				stall_left = draw_wait();
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// One register write. The copy is masked to the register width, so junk
	// in the upper data bits must be discarded by the block as well.
	task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		case (idx)
			REG_SETPOINT:    cp_setpoint = data[SAMPLE_W-1:0];
			REG_GAIN_P:      cp_gain_p = data[GAIN_W-1:0];
			REG_GAIN_I:      cp_gain_i = data[GAIN_W-1:0];
			REG_GAIN_D:      cp_gain_d = data[GAIN_W-1:0];
			REG_INTEG_UPPER: cp_integ_upper = data[INTEG_W-1:0];
			REG_INTEG_LOWER: cp_integ_lower = data[INTEG_W-1:0];
			REG_DRIVE_UPPER: cp_drive_upper = data[DRIVE_W-1:0];
			REG_DRIVE_LOWER: cp_drive_lower = data[DRIVE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [15:0] sp, input logic [15:0] kp,
			input logic [15:0] ki, input logic [15:0] kd, input logic [31:0] iup,
			input logic [31:0] ilo, input logic [15:0] dup, input logic [15:0] dlo);
		write_cfg(REG_SETPOINT, {16'($urandom), sp});
		write_cfg(REG_GAIN_P, {16'($urandom), kp});
		write_cfg(REG_GAIN_I, {16'($urandom), ki});
		write_cfg(REG_GAIN_D, {16'($urandom), kd});
		write_cfg(REG_INTEG_UPPER, iup);
		write_cfg(REG_INTEG_LOWER, ilo);
		write_cfg(REG_DRIVE_UPPER, {16'($urandom), dup});
		write_cfg(REG_DRIVE_LOWER, {16'($urandom), dlo});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until the driver has nothing left and every response is back,
	// then lets the block settle before it is treated as idle.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (stim_q.size() != 0 || presenting || drive_expect_q.size() != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
		endcase
	endfunction

	function automatic logic [15:0] pick_s16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [TIME_W-1:0] t_now;
		logic signed [31:0] a32, b32;
		logic signed [15:0] a16, b16;
		logic [31:0] iup, ilo;
		logic [15:0] dup, dlo;
		longint v;
		int mode;

		// Register defaults and cleared state, as after reset.
		cp_setpoint = 16'sd0;
		cp_gain_p = 16'd256;
		cp_gain_i = 16'd0;
		cp_gain_d = 16'd0;
		cp_integ_upper = 32'sh7FFF_FFFF;
		cp_integ_lower = 32'sd0;
		cp_drive_upper = 16'sh7FFF;
		cp_drive_lower = 16'sd0;
		pr_integral = '0;
		pr_prev_error = '0;
		pr_prev_time = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under the reset defaults. The first item sees the
		// raw timestamp as elapsed time; the second repeats it for zero dt.
		stim_q.push_back(mk_item(16'sh0100, 32'd1000, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0100, 32'd1000, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh7FFF, 32'd1010, 1'b1, 1'b0));
		stim_q.push_back(mk_item(-16'sh8000, 32'd1020, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'($urandom), $urandom, 1'b0, 1'b0));
		stim_q.push_back(mk_item(16'sh7FFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
		// Timestamp wrap across zero.
		stim_q.push_back(mk_item(16'sh0040, 32'hFFFF_FFF0, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0080, 32'h0000_0005, 1'b1, 1'b1));
		wait_quiet();

		// Derivative only, at full gain: a rise saturates the drive high, a
		// fall saturates it low, and a small change over 3 ms truncates.
		load_settings(16'h0100, 16'd0, 16'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			16'h7FFF, 16'h8000);
		stim_q.push_back(mk_item(16'sh7F00, 32'd6, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0000, 32'd7, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0105, 32'd10, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0200, 32'd10, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0101, 32'd11, 1'b1, 1'b0));
		wait_quiet();

		// Lowest setpoint with a tight integral window: the sum clamps high.
		load_settings(16'h8000, 16'd1, 16'hFFFF, 16'd0, 32'd1000, 32'hFFFF_FC18,
			16'h7FFF, 16'h8000);
		stim_q.push_back(mk_item(16'sh7FFF, 32'h8000_0000, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0000, 32'h8000_0001, 1'b0, 1'b0));
		stim_q.push_back(mk_item(-16'sh8000, 32'h8000_0002, 1'b1, 1'b0));
		wait_quiet();

		// Crossed limits on both the integral and the drive.
		load_settings(16'h0000, 16'd300, 16'd7, 16'd50, 32'hFFFF_EC78, 32'd5000,
			16'hFF9C, 16'd100);
		stim_q.push_back(mk_item(16'sh0400, 32'h8000_0010, 1'b1, 1'b0));
		stim_q.push_back(mk_item(16'sh0000, 32'h8000_0020, 1'b1, 1'b0));
		wait_quiet();

		// A lower integral limit above the present sum pulls it up to the limit.
		load_settings(16'h7FFF, 16'h0080, 16'd1, 16'd0, 32'h7FFF_FFFF, 32'h0010_0000,
			16'h7FFF, 16'h0000);
		stim_q.push_back(mk_item(16'sh7FFF, 32'h8000_0030, 1'b1, 1'b0));
		stim_q.push_back(mk_item(-16'sh0001, 32'h8000_0031, 1'b1, 1'b0));
		wait_quiet();

		// Random phases, each under fresh settings. Most samples stay near the
		// setpoint and most timestamps advance a little, so the integral and
		// the derivative stay in play; jumps, wraps and faults are mixed in.
		t_now = 32'h8000_0040;
		for (int ph = 0; ph < 10; ph++) begin
			mode = $urandom_range(0, 7);
			if (mode == 0) begin
				iup = 32'h7FFF_FFFF;
				ilo = 32'h8000_0000;
			end else if (mode == 1) begin
				iup = $urandom;
				ilo = $urandom;
			end else if (mode == 2) begin
				iup = 32'h7FFF_FFFF;
				ilo = 32'd0;
			end else begin
				a32 = 32'(signed'($urandom)) >>> $urandom_range(0, 24);
				b32 = 32'(signed'($urandom)) >>> $urandom_range(0, 24);
				iup = (a32 > b32) ? a32 : b32;
				ilo = (a32 > b32) ? b32 : a32;
			end
			mode = $urandom_range(0, 5);
			if (mode == 0) begin
				dup = 16'h7FFF;
				dlo = 16'h8000;
			end else if (mode == 1) begin
				dup = 16'($urandom);
				dlo = 16'($urandom);
			end else begin
				a16 = pick_s16();
				b16 = pick_s16();
				dup = (a16 > b16) ? a16 : b16;
				dlo = (a16 > b16) ? b16 : a16;
			end
			load_settings(pick_s16(), pick_gain(), pick_gain(), pick_gain(), iup, ilo,
				dup, dlo);
			calm = (ph % 3 == 1);
			repeat (185) begin
				mode = $urandom_range(0, 99);
				if (mode < 3)
					t_now = $urandom;
				else if (mode < 5)
					t_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
				else if (mode >= 12)
					t_now += $urandom_range(1, 40);
				if ($urandom_range(0, 9) < 2) begin
					a16 = 16'($urandom);
				end else begin
					v = longint'(cp_setpoint) + $urandom_range(0, 4096) - 2048;
					if (v > 32767)
						v = 32767;
					else if (v < -32768)
						v = -32768;
					a16 = 16'(v);
				end
				if ($urandom_range(0, 9) == 0)
					stim_q.push_back(mk_item(a16, $urandom, 1'b0,
						$urandom_range(0, 60) == 0));
				else
					stim_q.push_back(mk_item(a16, t_now, 1'b1,
						$urandom_range(0, 60) == 0));
			end
			wait_quiet();
		end

		calm = 1'b0;
		wait_quiet();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: the slowest correct run is far below this.
	initial begin
		#6_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
sv/ospid_pkg.sv
sv/ospid_smul.sv
sv/ospid_sdiv.sv
sv/one_sided_pid_controller_core.sv
tb/one_sided_pid_controller_core_tb.sv
